// ===== hw/rtl/ttlrfh_pkg.sv =====
// shared constants, types and codes of the ttl rate feedback histogram
package ttlrfh_pkg;

  // defaults for the top-level parameters
  localparam int unsigned NUM_BINS_DEF    = 12;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // item field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TTL_W       = 8;
  localparam int unsigned BIN_IDX_W   = 4;
  localparam int unsigned BIN_CNT_W   = 16;
  localparam int unsigned OWN_ID_W    = 3;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  // ttl layout
  localparam int unsigned RATE_W      = 5;
  localparam int unsigned LEADER_LSB  = 5;
  localparam logic [RATE_W-1:0] RATE_BASE = 5'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUMP_THR   = 2'd2;

  // register reset values
  localparam logic [ADDR_W-1:0]   GROUP_ADDR_RST = 32'hE000_4343;
  localparam logic [OWN_ID_W-1:0] OWN_ID_RST     = 3'd3;
  localparam logic [THR_W-1:0]    DUMP_THR_RST   = 16'd40;

  // leader id that every node follows
  localparam logic [OWN_ID_W-1:0] LEADER_ANY = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DUMP_RD,
    ST_DUMP_WR
  } state_e;

  // bin memory access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } mem_ctl_t;

endpackage

// ===== hw/rtl/ttlrfh_if.sv =====
// valid/ready channels for packet events and histogram results
interface ttlrfh_in_if;
  logic                              valid;
  logic                              ready;
  logic [ttlrfh_pkg::ADDR_W-1:0]     dest_addr;
  logic [ttlrfh_pkg::TTL_W-1:0]      ttl_value;

  modport source (output valid, output dest_addr, output ttl_value, input ready);
  modport sink   (input valid, input dest_addr, input ttl_value, output ready);
endinterface

interface ttlrfh_out_if;
  logic                              valid;
  logic                              ready;
  logic [ttlrfh_pkg::BIN_IDX_W-1:0]  bin_index;
  logic [ttlrfh_pkg::BIN_CNT_W-1:0]  bin_count;
  logic                              last_bin;

  modport source (output valid, output bin_index, output bin_count, output last_bin,
                  input ready);
  modport sink   (input valid, input bin_index, input bin_count, input last_bin,
                  output ready);
endinterface

// ===== hw/rtl/ttlrfh_bin_mem.sv =====
// rate bin memory with per-entry valid bits and registered read
module ttlrfh_bin_mem #(
  parameter int unsigned NUM_BINS    = ttlrfh_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = ttlrfh_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned AW          = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ttlrfh_pkg::mem_ctl_t   ctl_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [COUNT_WIDTH-1:0] wr_data_i,
  output logic [COUNT_WIDTH-1:0] rd_data_o
);

  logic [COUNT_WIDTH-1:0] mem_q [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic [NUM_BINS-1:0]    vld_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // a cleared or never written entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end else if (ctl_i.clr_en) begin
        vld_q[wr_addr_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/ttlrfh_ctrl.sv =====
// event decode, read-modify-write sequencer and dump output stage
module ttlrfh_ctrl #(
  parameter int unsigned NUM_BINS    = ttlrfh_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = ttlrfh_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned AW          = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ttlrfh_in_if.sink                           ev_i,
  ttlrfh_out_if.source                        res_o,
  input  logic [ttlrfh_pkg::ADDR_W-1:0]       group_addr_i,
  input  logic [ttlrfh_pkg::OWN_ID_W-1:0]     own_id_i,
  input  logic [ttlrfh_pkg::THR_W-1:0]        dump_thr_i,
  output ttlrfh_pkg::mem_ctl_t                mem_ctl_o,
  output logic [AW-1:0]                       mem_rd_addr_o,
  output logic [AW-1:0]                       mem_wr_addr_o,
  output logic [COUNT_WIDTH-1:0]              mem_wr_data_o,
  input  logic [COUNT_WIDTH-1:0]              mem_rd_data_i
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > ttlrfh_pkg::THR_W) ?
                                  COUNT_WIDTH : ttlrfh_pkg::THR_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BINS - 1);

  ttlrfh_pkg::state_e state_q, state_d;

  logic [AW-1:0]          bin_q, bin_d;
  logic                   bin_ok_q, bin_ok_d;
  logic                   lead_ok_q, lead_ok_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [COUNT_WIDTH-1:0] pkt_cnt_q, pkt_cnt_d;

  logic                              out_vld_q, out_vld_d;
  logic [ttlrfh_pkg::BIN_IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [ttlrfh_pkg::BIN_CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic                              out_last_q, out_last_d;

  // input decode
  logic                               accept;
  logic                               match;
  logic [ttlrfh_pkg::RATE_W-1:0]      rate;
  logic [ttlrfh_pkg::OWN_ID_W-1:0]    leader;
  logic [ttlrfh_pkg::RATE_W-1:0]      rate_off;
  logic [ttlrfh_pkg::BIN_IDX_W-1:0]   bin_raw;
  logic                               bin_in_range;

  // update path
  logic [COUNT_WIDTH-1:0] bin_inc;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   dump_go;
  logic                   out_free;

  assign ev_i.ready   = (state_q == ttlrfh_pkg::ST_IDLE);
  assign accept       = ev_i.valid && ev_i.ready;
  assign match        = (ev_i.dest_addr == group_addr_i);
  assign rate         = ev_i.ttl_value[ttlrfh_pkg::RATE_W-1:0];
  assign leader       = ev_i.ttl_value[ttlrfh_pkg::LEADER_LSB +: ttlrfh_pkg::OWN_ID_W];
  assign rate_off     = rate - ttlrfh_pkg::RATE_BASE;
  assign bin_raw      = rate_off[ttlrfh_pkg::RATE_W-1:1];
  assign bin_in_range = (rate >= ttlrfh_pkg::RATE_BASE) &&
                        (6'(bin_raw) < 6'(NUM_BINS));

  // saturating increments
  assign bin_inc = (&mem_rd_data_i) ? mem_rd_data_i : mem_rd_data_i + 1'b1;
  assign cnt_inc = (&pkt_cnt_q) ? pkt_cnt_q : pkt_cnt_q + 1'b1;
  assign dump_go = (CMP_W'(cnt_inc) > CMP_W'(dump_thr_i)) && lead_ok_q;

  assign out_free = !out_vld_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttlrfh_pkg::ST_IDLE: begin
        if (accept && match) begin
          state_d = ttlrfh_pkg::ST_UPDATE;
        end
      end
      ttlrfh_pkg::ST_UPDATE: begin
        state_d = dump_go ? ttlrfh_pkg::ST_DUMP_RD : ttlrfh_pkg::ST_IDLE;
      end
      ttlrfh_pkg::ST_DUMP_RD: begin
        state_d = ttlrfh_pkg::ST_DUMP_WR;
      end
      ttlrfh_pkg::ST_DUMP_WR: begin
        if (out_free) begin
          state_d = (idx_q == LAST_IDX) ? ttlrfh_pkg::ST_IDLE : ttlrfh_pkg::ST_DUMP_RD;
        end
      end
      default: begin
        state_d = ttlrfh_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    bin_d      = bin_q;
    bin_ok_d   = bin_ok_q;
    lead_ok_d  = lead_ok_q;
    idx_d      = idx_q;
    pkt_cnt_d  = pkt_cnt_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    out_idx_d  = out_idx_q;
    out_cnt_d  = out_cnt_q;
    out_last_d = out_last_q;

    mem_ctl_o     = '0;
    mem_rd_addr_o = idx_q;
    mem_wr_addr_o = idx_q;
    mem_wr_data_o = bin_inc;

    unique case (state_q)
      ttlrfh_pkg::ST_IDLE: begin
        mem_rd_addr_o = AW'(bin_raw);
        if (accept && match) begin
          mem_ctl_o.rd_en = 1'b1;
          bin_d     = AW'(bin_raw);
          bin_ok_d  = bin_in_range;
          lead_ok_d = (leader == own_id_i) || (leader == ttlrfh_pkg::LEADER_ANY);
        end
      end
      ttlrfh_pkg::ST_UPDATE: begin
        mem_wr_addr_o   = bin_q;
        mem_ctl_o.wr_en = bin_ok_q;
        if (dump_go) begin
          pkt_cnt_d = '0;
          idx_d     = '0;
        end else begin
          pkt_cnt_d = cnt_inc;
        end
      end
      ttlrfh_pkg::ST_DUMP_RD: begin
        mem_ctl_o.rd_en = 1'b1;
      end
      ttlrfh_pkg::ST_DUMP_WR: begin
        if (out_free) begin
          mem_ctl_o.clr_en = 1'b1;
          out_vld_d  = 1'b1;
          out_idx_d  = ttlrfh_pkg::BIN_IDX_W'(idx_q);
          out_cnt_d  = ttlrfh_pkg::BIN_CNT_W'(mem_rd_data_i);
          out_last_d = (idx_q == LAST_IDX);
          idx_d      = idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttlrfh_pkg::ST_IDLE;
      idx_q     <= '0;
      pkt_cnt_q <= '0;
      out_vld_q <= 1'b0;
      bin_ok_q  <= 1'b0;
      lead_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pkt_cnt_q <= pkt_cnt_d;
      out_vld_q <= out_vld_d;
      bin_ok_q  <= bin_ok_d;
      lead_ok_q <= lead_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    out_idx_q  <= out_idx_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.bin_index = out_idx_q;
  assign res_o.bin_count = out_cnt_q;
  assign res_o.last_bin  = out_last_q;

endmodule

// ===== hw/rtl/ttl_rate_feedback_histogram_top.sv =====
// top level of the ttl rate feedback histogram: registers, sequencer, bin memory
//
// Counts packet events addressed to one multicast group and sorts them into
// NUM_BINS rate bins by the low five ttl bits (codes 4 to 27 with the default
// twelve bins, two codes per bin; other codes only count the packet). Once the
// saturating packet count exceeds dump_threshold on a packet whose leader id
// (ttl bits 7..5) is this node's own_id or 0, the block clears the count and
// reports every bin in order, one item per bin with last_bin set on the final
// one, clearing each bin as it is reported. A matching packet goes through the
// read-modify-write of the bin memory (read in the accept cycle, write back in
// the next); a dump reads each bin from memory, then loads it into the output
// register, and stalls while the result sink is not ready. No new packet is
// taken until both are done. The last result of a dump may still wait in the
// output register while the next packet is taken. Bins start cleared through
// per-entry valid bits, so there is no clearing pass after reset. The user must
// write registers through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is
// idle; the block does not enforce this. Unknown indexes are ignored.
module ttl_rate_feedback_histogram_top #(
  parameter int unsigned NUM_BINS    = ttlrfh_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = ttlrfh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  ttlrfh_in_if.sink                            ev_i,
  ttlrfh_out_if.source                         res_o,
  input  logic                                 cfg_we_i,
  input  logic [ttlrfh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ttlrfh_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // bin memory address width
  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // configuration registers
  logic [ttlrfh_pkg::ADDR_W-1:0]   group_addr_q;
  logic [ttlrfh_pkg::OWN_ID_W-1:0] own_id_q;
  logic [ttlrfh_pkg::THR_W-1:0]    dump_thr_q;

  // sequencer to memory
  ttlrfh_pkg::mem_ctl_t   mem_ctl;
  logic [AW-1:0]          mem_rd_addr;
  logic [AW-1:0]          mem_wr_addr;
  logic [COUNT_WIDTH-1:0] mem_wr_data;
  logic [COUNT_WIDTH-1:0] mem_rd_data;

  // register writes, each masked to its register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_addr_q <= ttlrfh_pkg::GROUP_ADDR_RST;
      own_id_q     <= ttlrfh_pkg::OWN_ID_RST;
      dump_thr_q   <= ttlrfh_pkg::DUMP_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttlrfh_pkg::CFG_GROUP_ADDR: group_addr_q <= cfg_data_i[ttlrfh_pkg::ADDR_W-1:0];
        ttlrfh_pkg::CFG_OWN_ID:     own_id_q     <= cfg_data_i[ttlrfh_pkg::OWN_ID_W-1:0];
        ttlrfh_pkg::CFG_DUMP_THR:   dump_thr_q   <= cfg_data_i[ttlrfh_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // event decode, packet count, bin update and dump sequencing
  ttlrfh_ctrl #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_i          (ev_i),
    .res_o         (res_o),
    .group_addr_i  (group_addr_q),
    .own_id_i      (own_id_q),
    .dump_thr_i    (dump_thr_q),
    .mem_ctl_o     (mem_ctl),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data)
  );

  // the rate bins themselves
  ttlrfh_bin_mem #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW)
  ) u_bin_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

endmodule
